// ===== sv/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants of the cosine similarity batch unit.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int ACC_W = 48;
    localparam int MAG_W = 24;
    localparam int SIM_W = 16;
    localparam int CNT_W = 16;

    typedef enum logic [1:0] {
        OUT_VALID    = 2'd0,
        OUT_ZERO_MAG = 2'd1,
        OUT_MISMATCH = 2'd2
    } t_outcome;

    // One finished candidate, handed from the front end to the back end.
    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] q_sum;
        logic [ACC_W-1:0] c_sum;
        logic [MAG_W-1:0] given;
        logic             use_given;
        logic             mismatch;
        logic [CNT_W-1:0] number;
    } t_job;

    // One result item.
    typedef struct packed {
        logic [SIM_W-1:0] sim;
        t_outcome         outcome;
        logic [CNT_W-1:0] number;
    } t_result;

endpackage

// ===== sv/cosine_similarity_batch_unit.sv =====
// ----------------------------------------------------------------------------
// An element is taken every cycle unless a finished candidate waits for the back
// end; a candidate's result follows its last element after two 24-step square
// roots, one multiply and a 63-step divide. The back end takes one candidate
// at a time, so short candidates wait on it; else one element per cycle is taken.
// Reset is synchronous, active low; the query RAM is not cleared.
// ----------------------------------------------------------------------------
// cosine_similarity_batch_unit
// Streams a query and candidates and returns their cosine similarity.
// ----------------------------------------------------------------------------
module cosine_similarity_batch_unit #(
    parameter int MAX_DIMENSIONS = 1024,
    parameter int ELEMENT_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,       // use_given_magnitudes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,     // element[15:0], given_magnitude[39:16]
    input  logic        s_axis_tlast,     // last_element
    input  logic        s_axis_tuser,     // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata      // similarity, outcome, candidate_number, pad
);
    import csb_pkg::*;

    logic    r_use_given;
    logic    w_jv, w_jr;
    t_job    w_job;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_given <= 1'b0;
        end else if (i_cfg_valid) begin
            r_use_given <= i_cfg_data;
        end
    end

    csb_front #(.MAX_DIMENSIONS(MAX_DIMENSIONS), .ELEMENT_BITS(ELEMENT_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_element(s_axis_tdata[15:0]),
        .i_last(s_axis_tlast), .i_given(s_axis_tdata[39:16]),
        .i_use_given(r_use_given),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    csb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.number, 2'(w_res.outcome), w_res.sim};

    // A result that is not valid carries a zero similarity.
    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] != 2'd0 |-> m_axis_tdata[15:0] == 16'd0)
        else $error("nonzero similarity with error outcome");
    // Outcome code three never appears.
    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
        else $error("bad outcome");
    // A job that the front end offers stays offered until the back end takes it.
    a_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_jv && !w_jr |=> w_jv)
        else $error("job dropped");
endmodule

// ===== sv/csb_ram.sv =====
// ----------------------------------------------------------------------------
// csb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module csb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/csb_front.sv =====
// ----------------------------------------------------------------------------
// csb_front
// Accepts elements, stores the query and accumulates candidate sums; emits
// one job per finished candidate. Two stage pipeline around the query RAM.
// ----------------------------------------------------------------------------
module csb_front #(
    parameter int MAX_DIMENSIONS = 1024,
    parameter int ELEMENT_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_kind,
    input  logic [15:0]            i_element,
    input  logic                   i_last,
    input  logic [23:0]            i_given,
    input  logic                   i_use_given,
    output logic                   o_job_valid,
    input  logic                   i_job_ready,
    output csb_pkg::t_job          o_job
);
    import csb_pkg::*;

    localparam int AW  = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int LW  = $clog2(MAX_DIMENSIONS + 2);
    localparam logic [LW-1:0] MAXD = LW'(MAX_DIMENSIONS);

    logic [LW-1:0]    r_qlen, r_cpos;
    logic [ACC_W-1:0] r_qsum, r_dot, r_csum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_loading;

    // Stage 2 holds a candidate element while the query entry is read.
    logic             r_s2_valid, r_s2_acc, r_s2_last, r_s2_use;
    logic [ELEMENT_BITS-1:0] r_s2_e;
    logic [MAG_W-1:0] r_s2_given;
    logic [LW-1:0]    r_s2_pos;
    logic [AW-1:0]    r_s2_addr;
    logic [15:0]      w_q;

    logic             r_job_valid;
    t_job             r_job;

    logic w_acc, w_s2_go, w_job_push;
    logic signed [ELEMENT_BITS-1:0] w_e;
    logic signed [ACC_W-1:0] w_ee, w_s2_ee, w_s2_eq;
    logic [AW-1:0] w_raddr;
    logic [LW-1:0] w_pos_next;

    // Stage 2 may move when it can leave its job.
    assign w_s2_go    = !(r_s2_valid && r_s2_last && r_job_valid && !i_job_ready);
    assign o_ready    = w_s2_go;
    assign w_acc      = i_valid && o_ready;
    assign w_e        = $signed(i_element[ELEMENT_BITS-1:0]);
    assign w_ee       = ACC_W'(w_e) * ACC_W'(w_e);
    assign w_s2_ee    = ACC_W'($signed(r_s2_e)) * ACC_W'($signed(r_s2_e));
    assign w_s2_eq    = ACC_W'($signed(r_s2_e)) * ACC_W'($signed(w_q));
    assign w_job_push = r_s2_valid && r_s2_last;
    // While stage 2 waits, keep reading its own query entry.
    assign w_raddr    = w_s2_go ? r_cpos[AW-1:0] : r_s2_addr;
    assign w_pos_next = (r_cpos <= MAXD) ? r_cpos + 1'b1 : r_cpos;

    csb_ram #(.WIDTH(16), .DEPTH(MAX_DIMENSIONS)) u_qram (
        .i_clk  (i_clk),
        .i_we   (w_acc && !i_kind && ((!r_loading) || (r_qlen < MAXD))),
        .i_waddr(r_loading ? r_qlen[AW-1:0] : AW'(0)),
        .i_wdata(16'(w_e)),
        .i_raddr(w_raddr),
        .o_rdata(w_q)
    );

    // Query loading, candidate position and accumulation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0; r_cpos <= '0; r_qsum <= '0; r_dot <= '0; r_csum <= '0;
            r_cnt <= '0; r_loading <= 1'b0; r_s2_valid <= 1'b0; r_job_valid <= 1'b0;
        end else begin
            if (r_job_valid && i_job_ready) begin
                r_job_valid <= 1'b0;
            end
            if (w_s2_go) begin
                r_s2_valid <= 1'b0;
                // Retire the staged candidate element.
                if (r_s2_valid) begin
                    logic [ACC_W-1:0] v_dot, v_csum;
                    v_dot  = r_s2_acc ? r_dot + w_s2_eq : r_dot;
                    v_csum = r_s2_acc ? r_csum + w_s2_ee : r_csum;
                    r_dot  <= v_dot;
                    r_csum <= v_csum;
                    if (r_s2_last) begin
                        r_job_valid     <= 1'b1;
                        r_job.dot       <= v_dot;
                        r_job.q_sum     <= r_qsum;
                        r_job.c_sum     <= v_csum;
                        r_job.given     <= r_s2_given;
                        r_job.use_given <= r_s2_use;
                        r_job.mismatch  <= (r_s2_pos != r_qlen);
                        r_job.number    <= r_cnt;
                        r_cnt  <= r_cnt + 1'b1;
                        r_dot  <= '0;
                        r_csum <= '0;
                    end
                end
                if (w_acc) begin
                    if (!i_kind) begin
                        // Query element; a fresh load clears everything.
                        if (!r_loading) begin
                            r_qlen <= LW'(1); r_qsum <= w_ee; r_cnt <= '0;
                            r_cpos <= '0; r_dot <= '0; r_csum <= '0;
                        end else if (r_qlen < MAXD) begin
                            r_qlen <= r_qlen + 1'b1;
                            r_qsum <= r_qsum + w_ee;
                        end
                        // A query element discards a partial candidate.
                        if (r_loading) begin
                            r_cpos <= '0; r_dot <= '0; r_csum <= '0;
                        end
                        r_loading <= !i_last;
                    end else begin
                        r_loading  <= 1'b0;
                        r_s2_valid <= 1'b1;
                        r_s2_acc   <= (r_cpos < r_qlen) && (r_cpos < MAXD);
                        r_s2_last  <= i_last;
                        r_s2_e     <= i_element[ELEMENT_BITS-1:0];
                        r_s2_given <= i_given;
                        r_s2_use   <= i_use_given;
                        r_s2_pos   <= w_pos_next;
                        r_s2_addr  <= r_cpos[AW-1:0];
                        r_cpos     <= i_last ? '0 : w_pos_next;
                    end
                end
            end
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
endmodule

// ===== sv/csb_back.sv =====
// ----------------------------------------------------------------------------
// csb_back
// Square roots and division for one job at a time, bit serial, with an
// output register toward the result channel.
// ----------------------------------------------------------------------------
module csb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  csb_pkg::t_job     i_job,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output csb_pkg::t_result  o_res
);
    import csb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQRTQ, S_SQRTC, S_MUL, S_DIV, S_OUT
    } t_state;

    localparam int DEN_W = 2 * MAG_W;
    localparam int NUM_W = ACC_W + 15;

    t_state           r_state;
    t_job             r_job;
    logic [ACC_W-1:0] r_rem, r_root;
    logic [5:0]       r_step;
    logic [MAG_W-1:0] r_magq, r_magc;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W:0]   r_drem;
    logic             r_neg;
    t_result          r_res;
    logic             r_out_valid;
    t_result          r_out;

    logic [ACC_W-1:0] w_bit, w_trial;
    logic [DEN_W:0]   w_dsh;

    assign w_bit   = ACC_W'(1) << {r_step[4:0], 1'b0};
    assign w_trial = r_root + w_bit;
    assign w_dsh   = {r_drem[DEN_W-1:0], r_num[NUM_W-1]};

    assign o_job_ready = (r_state == S_IDLE);

    // Sequencer: two isqrt passes, one multiply, a restoring divide (skipped on mismatch or zero magnitude).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job; r_rem <= i_job.q_sum; r_root <= '0;
                        r_step <= 6'd23; r_state <= S_SQRTQ;
                    end
                end
                S_SQRTQ, S_SQRTC: begin
                    logic [ACC_W-1:0] v_root;
                    if (r_rem >= w_trial) begin
                        r_rem  <= r_rem - w_trial;
                        v_root = (r_root >> 1) + w_bit;
                    end else begin
                        v_root = r_root >> 1;
                    end
                    r_root <= v_root;
                    r_step <= r_step - 1'b1;
                    if (r_step == 6'd0) begin
                        if (r_state == S_SQRTQ) begin
                            r_magq <= v_root[MAG_W-1:0];
                            r_rem <= r_job.c_sum; r_root <= '0; r_step <= 6'd23;
                            r_state <= S_SQRTC;
                        end else begin
                            r_magc <= v_root[MAG_W-1:0];
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    logic [MAG_W-1:0] v_magc;
                    v_magc = r_job.use_given ? r_job.given : r_magc;
                    r_magc <= v_magc;
                    r_den  <= DEN_W'(r_magq) * DEN_W'(v_magc);
                    r_neg  <= r_job.dot[ACC_W-1];
                    r_num  <= {(r_job.dot[ACC_W-1] ? -r_job.dot : r_job.dot), 15'd0};
                    r_drem <= '0;
                    r_step <= 6'(NUM_W - 1);
                    if (r_job.mismatch || r_magq == '0 || v_magc == '0) begin
                        r_res.sim     <= '0;
                        r_res.outcome <= r_job.mismatch ? OUT_MISMATCH : OUT_ZERO_MAG;
                        r_res.number  <= r_job.number;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    logic [NUM_W-1:0] v_num;
                    logic             v_q;
                    v_q = (w_dsh >= {1'b0, r_den});
                    r_drem <= v_q ? w_dsh - {1'b0, r_den} : w_dsh;
                    v_num = {r_num[NUM_W-2:0], v_q};
                    r_num <= v_num;
                    r_step <= r_step - 1'b1;
                    if (r_step == 6'd0) begin
                        if (r_neg) begin
                            r_res.sim <= (v_num > NUM_W'(32768)) ? 16'h8000
                                       : 16'(17'h10000 - 17'(v_num));
                        end else begin
                            r_res.sim <= (v_num > NUM_W'(32767)) ? 16'h7FFF : 16'(v_num);
                        end
                        r_res.outcome <= OUT_VALID;
                        r_res.number  <= r_job.number;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Load the output register once the previous result has left.
                    if (!r_out_valid || i_res_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
endmodule
